// ----- src/tcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the triangle coverage grid rasterizer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

	localparam int GRID_W_DEF = 32;
	localparam int GRID_H_DEF = 16;

	localparam logic [2:0] OP_COEF   = 3'd0;
	localparam logic [2:0] OP_VERT   = 3'd1;
	localparam logic [2:0] OP_CLOSE  = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_CLROCC = 3'd4;

	localparam logic [2:0] CLS_EMPTY    = 3'd0;
	localparam logic [2:0] CLS_INTERIOR = 3'd1;
	localparam logic [2:0] CLS_CORNER   = 3'd2;
	localparam logic [2:0] CLS_HBORDER  = 3'd3;
	localparam logic [2:0] CLS_VBORDER  = 3'd4;

	localparam logic KIND_CLOSE = 1'b0;
	localparam logic KIND_CLASS = 1'b1;

	localparam logic [1:0] CFG_CENTER_X  = 2'd0;
	localparam logic [1:0] CFG_CENTER_Y  = 2'd1;
	localparam logic [1:0] CFG_CELL_SIZE = 2'd2;
	localparam logic [1:0] CFG_MIN_CELLS = 2'd3;

	localparam logic [30:0] CELL_SIZE_RST = 31'd12288;
	localparam logic [9:0]  MIN_CELLS_RST = 10'd2;
	localparam int          RND_HALF      = 32768;
	localparam int          HIT_MAX       = 1023;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [2:0]         position_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic [4:0]         cell_x;
		logic [3:0]         cell_y;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [9:0] hit_count;
		logic       accepted;
		logic [2:0] cell_class;
	} out_item_t;

endpackage

// ----- src/tcgr_ram.sv -----
// ----------------------------------------------------------------------------
// tcgr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/triangle_coverage_grid_raster_top.sv -----
// ----------------------------------------------------------------------------
// triangle_coverage_grid_raster_top
// Transforms vertices, rasterizes triangles into an object grid, merges
// closed objects into an occupancy grid and classifies occupancy cells.
// ----------------------------------------------------------------------------
// One item is worked on at a time; busy is high until it is finished. A
// coefficient write, occupancy clear or ignored item is handled in the idle
// state. After a vertex is transformed, vertex 2 rasterizes: four 33-step
// divisions for the box, twelve 48-step serial products for the edge
// functions, then a walk along each box row, one column at a time. A close
// reads each object grid row once and, when merged, reads and writes back
// each occupancy row. A query reads three occupancy rows.
// Results appear on result for one cycle with done high and cannot be stalled.
// Both grids are row memories with per-row valid bits, so no clearing pass is
// needed after reset.
module triangle_coverage_grid_raster_top #(
	parameter int GRID_W = tcgr_pkg::GRID_W_DEF,
	parameter int GRID_H = tcgr_pkg::GRID_H_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tcgr_pkg::in_item_t  item,
	output logic                done,
	output tcgr_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	import tcgr_pkg::*;

	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);
	localparam int CW = $clog2(GRID_W * GRID_H + 1);
	localparam int GW = 35;
	localparam int PW = 48;
	localparam int EW = 80;
	localparam logic signed [GW-1:0] HW_G = GW'(GRID_W / 2);
	localparam logic signed [GW-1:0] HH_G = GW'(GRID_H / 2);
	localparam logic signed [GW-1:0] XMAX_G = GW'(GRID_W - 1);
	localparam logic signed [GW-1:0] YMAX_G = GW'(GRID_H - 1);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_XFORM = 5'd1;
	localparam logic [4:0] S_XFIN  = 5'd2;
	localparam logic [4:0] S_DIVLD = 5'd3;
	localparam logic [4:0] S_DIV   = 5'd4;
	localparam logic [4:0] S_DIVST = 5'd5;
	localparam logic [4:0] S_CLAMP = 5'd6;
	localparam logic [4:0] S_SETUP = 5'd7;
	localparam logic [4:0] S_MLD   = 5'd8;
	localparam logic [4:0] S_MRUN  = 5'd9;
	localparam logic [4:0] S_MST   = 5'd10;
	localparam logic [4:0] S_ROWRD = 5'd11;
	localparam logic [4:0] S_WALK  = 5'd12;
	localparam logic [4:0] S_ROWWR = 5'd13;
	localparam logic [4:0] S_CNTRD = 5'd14;
	localparam logic [4:0] S_CNTAD = 5'd15;
	localparam logic [4:0] S_MGRD  = 5'd16;
	localparam logic [4:0] S_MGWR  = 5'd17;
	localparam logic [4:0] S_CFIN  = 5'd18;
	localparam logic [4:0] S_QRD   = 5'd19;
	localparam logic [4:0] S_QCAP  = 5'd20;
	localparam logic [4:0] S_QFIN  = 5'd21;

	logic [4:0]               state_q;
	logic signed [31:0]       coef_q [8];
	logic signed [31:0]       vx_q [3];
	logic signed [31:0]       vy_q [3];
	logic signed [31:0]       cx_q;
	logic signed [31:0]       cy_q;
	logic [30:0]              cs_q;
	logic [9:0]               minc_q;
	in_item_t                 in_q;
	logic [2:0]               t_q;
	logic signed [63:0]       prod_q;
	logic signed [65:0]       accx_q;
	logic signed [65:0]       accy_q;
	logic [1:0]               div_idx_q;
	logic [5:0]               div_cnt_q;
	logic [32:0]              div_a_q;
	logic [30:0]              div_rem_q;
	logic                     div_neg_q;
	logic signed [GW-1:0]     g_q [4];
	logic signed [PW-1:0]     px0_q;
	logic signed [PW-1:0]     py0_q;
	logic [3:0]               m_q;
	logic [5:0]               mcnt_q;
	logic [96:0]              mp_q;
	logic [PW-1:0]            ma_q;
	logic                     mneg_q;
	logic signed [EW-1:0]     rs_q [3];
	logic signed [EW-1:0]     ce_q [3];
	logic signed [EW-1:0]     sx_q [3];
	logic signed [EW-1:0]     sy_q [3];
	logic [XW-1:0]            gx_q;
	logic [YW-1:0]            gy_q;
	logic [GRID_W-1:0]        mask_q;
	logic [GRID_H-1:0]        obj_vld_q;
	logic [GRID_H-1:0]        occ_vld_q;
	logic [CW-1:0]            cnt_q;
	logic [YW-1:0]            r_q;
	logic [1:0]               qk_q;
	logic                     qok_q;
	logic [YW-1:0]            qaddr_q;
	logic [GRID_W-1:0]        qrow_q [3];
	logic                     done_q;
	out_item_t                res_q;

	logic                     obj_we;
	logic [YW-1:0]            obj_waddr;
	logic [GRID_W-1:0]        obj_wdata;
	logic                     obj_re;
	logic [YW-1:0]            obj_raddr;
	logic [GRID_W-1:0]        obj_rdata;
	logic                     occ_we;
	logic [YW-1:0]            occ_waddr;
	logic [GRID_W-1:0]        occ_wdata;
	logic                     occ_re;
	logic [YW-1:0]            occ_raddr;
	logic [GRID_W-1:0]        occ_rdata;

	logic signed [31:0]       xf_coef;
	logic signed [31:0]       xf_coord;
	logic signed [31:0]       mnx, mxx, mny, mxy;
	logic signed [32:0]       div_d;
	logic [31:0]              div_trial;
	logic                     div_ge;
	logic signed [GW-1:0]     div_qs;
	logic signed [GW-1:0]     div_qf;
	logic signed [GW-1:0]     div_g;
	logic signed [GW-1:0]     cl_x0, cl_x1, cl_y0, cl_y1;
	logic signed [XW+2:0]     offx;
	logic signed [YW+2:0]     offy;
	logic signed [XW+34:0]    px_mul;
	logic signed [YW+34:0]    py_mul;
	logic signed [PW-1:0]     va_x, va_y, vb_x, vb_y;
	logic signed [PW-1:0]     cs2;
	logic signed [PW-1:0]     op_a, op_b;
	logic [48:0]              m_sum;
	logic [95:0]              m_mag;
	logic signed [EW-1:0]     m_res;
	logic                     cell_in;
	logic [GRID_W-1:0]        cnt_row;
	logic [CW-1:0]            cnt_n;
	logic [GRID_W-1:0]        merge_row;
	int                       q_ry;
	logic                     q_xok;
	logic                     q_c, q_up, q_dn, q_lf, q_rt, q_vb, q_hb;
	logic [2:0]               q_cls;
	logic [XW-1:0]            q_xi;
	logic [XW-1:0]            q_xl;
	logic [XW-1:0]            q_xr;

	function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] s);
		logic signed [65:0] w;
		logic signed [31:0] r;
		w = s >>> 16;
		if (w[65:31] == {35{w[65]}}) begin
			r = w[31:0];
		end else if (w[65]) begin
			r = {1'b1, 31'd0};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [XW:0] pcnt(input logic [GRID_W-1:0] v);
		logic [XW:0] c;
		c = '0;
		for (int i = 0; i < GRID_W; i++) begin
			c = c + (XW+1)'(v[i]);
		end
		return c;
	endfunction

	function automatic logic [PW-1:0] mag(input logic signed [PW-1:0] v);
		return v[PW-1] ? PW'(-v) : PW'(v);
	endfunction

	tcgr_ram #(.WIDTH(GRID_W), .DEPTH(GRID_H)) u_obj_ram (
		.clk   (clk),
		.we    (obj_we),
		.waddr (obj_waddr),
		.wdata (obj_wdata),
		.re    (obj_re),
		.raddr (obj_raddr),
		.rdata (obj_rdata)
	);

	tcgr_ram #(.WIDTH(GRID_W), .DEPTH(GRID_H)) u_occ_ram (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.re    (occ_re),
		.raddr (occ_raddr),
		.rdata (occ_rdata)
	);

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = res_q;

	always_comb begin
		case (t_q)
			3'd0: begin xf_coef = coef_q[0]; xf_coord = in_q.vert_x; end
			3'd1: begin xf_coef = coef_q[1]; xf_coord = in_q.vert_y; end
			3'd2: begin xf_coef = coef_q[2]; xf_coord = in_q.vert_z; end
			3'd3: begin xf_coef = coef_q[4]; xf_coord = in_q.vert_x; end
			3'd4: begin xf_coef = coef_q[5]; xf_coord = in_q.vert_y; end
			3'd5: begin xf_coef = coef_q[6]; xf_coord = in_q.vert_z; end
			default: begin xf_coef = '0; xf_coord = '0; end
		endcase
	end

	always_comb begin
		mnx = vx_q[0];
		mxx = vx_q[0];
		mny = vy_q[0];
		mxy = vy_q[0];
		for (int i = 1; i < 3; i++) begin
			if (vx_q[i] < mnx) mnx = vx_q[i];
			if (vx_q[i] > mxx) mxx = vx_q[i];
			if (vy_q[i] < mny) mny = vy_q[i];
			if (vy_q[i] > mxy) mxy = vy_q[i];
		end
		case (div_idx_q)
			2'd0: div_d = $signed({mnx[31], mnx}) - $signed({cx_q[31], cx_q});
			2'd1: div_d = $signed({mxx[31], mxx}) - $signed({cx_q[31], cx_q});
			2'd2: div_d = $signed({mny[31], mny}) - $signed({cy_q[31], cy_q});
			default: div_d = $signed({mxy[31], mxy}) - $signed({cy_q[31], cy_q});
		endcase
		div_trial = {div_rem_q, div_a_q[32]};
		div_ge    = (div_trial >= {1'b0, cs_q});
		div_qs    = $signed({2'b00, div_a_q});
		div_qf    = div_neg_q ? -(div_qs + GW'(|div_rem_q)) : div_qs;
		div_g     = div_qf + (div_idx_q[1] ? HH_G : HW_G) + GW'(div_idx_q[0]);
		cl_x0 = g_q[0][GW-1] ? '0 : g_q[0];
		cl_y0 = g_q[2][GW-1] ? '0 : g_q[2];
		cl_x1 = (g_q[1] > XMAX_G) ? XMAX_G : g_q[1];
		cl_y1 = (g_q[3] > YMAX_G) ? YMAX_G : g_q[3];
	end

	always_comb begin
		offx   = $signed({2'b00, g_q[0][XW-1:0], 1'b0}) - (XW+3)'(2 * (GRID_W / 2)) + (XW+3)'(1);
		offy   = $signed({2'b00, g_q[2][YW-1:0], 1'b0}) - (YW+3)'(2 * (GRID_H / 2)) + (YW+3)'(1);
		px_mul = offx * $signed({1'b0, cs_q});
		py_mul = offy * $signed({1'b0, cs_q});
		cs2    = $signed(PW'({cs_q, 1'b0}));
		case (m_q[3:2])
			2'd0: begin
				va_x = PW'(vx_q[0]) <<< 1; va_y = PW'(vy_q[0]) <<< 1;
				vb_x = PW'(vx_q[1]) <<< 1; vb_y = PW'(vy_q[1]) <<< 1;
			end
			2'd1: begin
				va_x = PW'(vx_q[1]) <<< 1; va_y = PW'(vy_q[1]) <<< 1;
				vb_x = PW'(vx_q[2]) <<< 1; vb_y = PW'(vy_q[2]) <<< 1;
			end
			default: begin
				va_x = PW'(vx_q[2]) <<< 1; va_y = PW'(vy_q[2]) <<< 1;
				vb_x = PW'(vx_q[0]) <<< 1; vb_y = PW'(vy_q[0]) <<< 1;
			end
		endcase
		case (m_q[1:0])
			2'd0: begin op_a = px0_q - vb_x; op_b = va_y - vb_y; end
			2'd1: begin op_a = va_x - vb_x;  op_b = py0_q - vb_y; end
			2'd2: begin op_a = cs2;          op_b = va_y - vb_y; end
			default: begin op_a = cs2;       op_b = va_x - vb_x; end
		endcase
		m_sum = mp_q[96:48] + (mp_q[0] ? {1'b0, ma_q} : 49'd0);
		m_mag = mp_q[95:0];
		m_res = mneg_q ? EW'(-m_mag) : EW'(m_mag);
	end

	always_comb begin
		cell_in = !((ce_q[0][EW-1] || ce_q[1][EW-1] || ce_q[2][EW-1]) &&
			((!ce_q[0][EW-1] && ce_q[0] != '0) || (!ce_q[1][EW-1] && ce_q[1] != '0) ||
			(!ce_q[2][EW-1] && ce_q[2] != '0)));
		cnt_row   = obj_vld_q[r_q] ? obj_rdata : '0;
		cnt_n     = cnt_q + CW'(pcnt(cnt_row));
		merge_row = (occ_vld_q[r_q] ? occ_rdata : '0) | (obj_vld_q[r_q] ? obj_rdata : '0);
		q_ry      = int'(in_q.cell_y) + int'(qk_q) - 1;
		q_xok     = int'(in_q.cell_x) < GRID_W;
		q_xi      = XW'(in_q.cell_x);
		q_xl      = XW'(int'(in_q.cell_x) - 1);
		q_xr      = XW'(int'(in_q.cell_x) + 1);
		q_c  = q_xok && qrow_q[1][q_xi];
		q_up = q_xok && qrow_q[0][q_xi];
		q_dn = q_xok && qrow_q[2][q_xi];
		q_lf = q_xok && in_q.cell_x != 5'd0 && qrow_q[1][q_xl];
		q_rt = q_xok && (int'(in_q.cell_x) + 1 < GRID_W) && qrow_q[1][q_xr];
		q_vb = !q_up || !q_dn;
		q_hb = !q_lf || !q_rt;
		if (!q_c) begin
			q_cls = CLS_EMPTY;
		end else if (!q_vb && !q_hb) begin
			q_cls = CLS_INTERIOR;
		end else if (q_vb && q_hb) begin
			q_cls = CLS_CORNER;
		end else if (q_vb) begin
			q_cls = CLS_HBORDER;
		end else begin
			q_cls = CLS_VBORDER;
		end
	end

	always_comb begin
		obj_we    = 1'b0;
		obj_waddr = gy_q;
		obj_wdata = (obj_vld_q[gy_q] ? obj_rdata : '0) | mask_q;
		obj_re    = 1'b0;
		obj_raddr = r_q;
		occ_we    = 1'b0;
		occ_waddr = r_q;
		occ_wdata = merge_row;
		occ_re    = 1'b0;
		occ_raddr = r_q;
		case (state_q)
			S_ROWRD: begin
				obj_re    = 1'b1;
				obj_raddr = gy_q;
			end
			S_ROWWR: obj_we = 1'b1;
			S_CNTRD: obj_re = 1'b1;
			S_MGRD: begin
				obj_re = 1'b1;
				occ_re = 1'b1;
			end
			S_MGWR: occ_we = 1'b1;
			S_QRD: begin
				occ_re    = 1'b1;
				occ_raddr = YW'(q_ry);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			cs_q   <= CELL_SIZE_RST;
			minc_q <= MIN_CELLS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CENTER_X:  cx_q <= cfg_data;
				CFG_CENTER_Y:  cy_q <= cfg_data;
				CFG_CELL_SIZE: cs_q <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
				CFG_MIN_CELLS: minc_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			coef_q    <= '{default: '0};
			obj_vld_q <= '0;
			occ_vld_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						in_q <= item;
						case (item.opcode)
							OP_COEF: coef_q[item.position_index] <= item.coef_value;
							OP_VERT: begin
								if (item.position_index <= 3'd2) begin
									t_q     <= '0;
									accx_q  <= '0;
									accy_q  <= '0;
									state_q <= S_XFORM;
								end
							end
							OP_CLOSE: begin
								cnt_q   <= '0;
								r_q     <= '0;
								state_q <= S_CNTRD;
							end
							OP_QUERY: begin
								qk_q    <= '0;
								state_q <= S_QRD;
							end
							OP_CLROCC: occ_vld_q <= '0;
							default: ;
						endcase
					end
				end
				S_XFORM: begin
					prod_q <= xf_coef * xf_coord;
					if (t_q != 3'd0) begin
						if (t_q <= 3'd3) begin
							accx_q <= accx_q + 66'(prod_q);
						end else begin
							accy_q <= accy_q + 66'(prod_q);
						end
					end
					t_q <= t_q + 3'd1;
					if (t_q == 3'd6) begin
						state_q <= S_XFIN;
					end
				end
				S_XFIN: begin
					vx_q[in_q.position_index[1:0]] <=
						rnd_sat(accx_q + (66'(coef_q[3]) <<< 8) + 66'(RND_HALF));
					vy_q[in_q.position_index[1:0]] <=
						rnd_sat(accy_q + (66'(coef_q[7]) <<< 8) + 66'(RND_HALF));
					if (in_q.position_index[1:0] == 2'd2) begin
						div_idx_q <= '0;
						state_q   <= S_DIVLD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIVLD: begin
					div_neg_q <= div_d[32];
					div_a_q   <= div_d[32] ? 33'(-div_d) : 33'(div_d);
					div_rem_q <= '0;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_rem_q <= div_ge ? 31'(div_trial - {1'b0, cs_q}) : div_trial[30:0];
					div_a_q   <= {div_a_q[31:0], div_ge};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd32) begin
						state_q <= S_DIVST;
					end
				end
				S_DIVST: begin
					g_q[div_idx_q] <= div_g;
					if (div_idx_q == 2'd3) begin
						state_q <= S_CLAMP;
					end else begin
						div_idx_q <= div_idx_q + 2'd1;
						state_q   <= S_DIVLD;
					end
				end
				S_CLAMP: begin
					g_q[0] <= cl_x0;
					g_q[1] <= cl_x1;
					g_q[2] <= cl_y0;
					g_q[3] <= cl_y1;
					if (cl_x0 > cl_x1 || cl_y0 > cl_y1) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					px0_q   <= (PW'(cx_q) <<< 1) + PW'(px_mul);
					py0_q   <= (PW'(cy_q) <<< 1) + PW'(py_mul);
					m_q     <= '0;
					state_q <= S_MLD;
				end
				S_MLD: begin
					ma_q    <= mag(op_a);
					mp_q    <= {49'd0, mag(op_b)};
					mneg_q  <= op_a[PW-1] ^ op_b[PW-1];
					mcnt_q  <= '0;
					state_q <= S_MRUN;
				end
				S_MRUN: begin
					mp_q   <= {m_sum, mp_q[47:0]} >> 1;
					mcnt_q <= mcnt_q + 6'd1;
					if (mcnt_q == 6'(PW - 1)) begin
						state_q <= S_MST;
					end
				end
				S_MST: begin
					case (m_q[1:0])
						2'd0: rs_q[m_q[3:2]] <= m_res;
						2'd1: rs_q[m_q[3:2]] <= rs_q[m_q[3:2]] - m_res;
						2'd2: sx_q[m_q[3:2]] <= m_res;
						default: sy_q[m_q[3:2]] <= -m_res;
					endcase
					if (m_q == 4'd11) begin
						gy_q    <= g_q[2][YW-1:0];
						state_q <= S_ROWRD;
					end else begin
						m_q     <= m_q + 4'd1;
						state_q <= S_MLD;
					end
				end
				S_ROWRD: begin
					ce_q    <= rs_q;
					gx_q    <= g_q[0][XW-1:0];
					mask_q  <= '0;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (cell_in) begin
						mask_q[gx_q] <= 1'b1;
					end
					for (int e = 0; e < 3; e++) begin
						ce_q[e] <= ce_q[e] + sx_q[e];
					end
					if (gx_q == g_q[1][XW-1:0]) begin
						state_q <= S_ROWWR;
					end else begin
						gx_q <= gx_q + XW'(1);
					end
				end
				S_ROWWR: begin
					obj_vld_q[gy_q] <= 1'b1;
					for (int e = 0; e < 3; e++) begin
						rs_q[e] <= rs_q[e] + sy_q[e];
					end
					if (gy_q == g_q[3][YW-1:0]) begin
						state_q <= S_IDLE;
					end else begin
						gy_q    <= gy_q + YW'(1);
						state_q <= S_ROWRD;
					end
				end
				S_CNTRD: state_q <= S_CNTAD;
				S_CNTAD: begin
					cnt_q <= cnt_n;
					if (r_q == YW'(GRID_H - 1)) begin
						r_q <= '0;
						if (32'(cnt_n) >= 32'(minc_q)) begin
							state_q <= S_MGRD;
						end else begin
							state_q <= S_CFIN;
						end
					end else begin
						r_q     <= r_q + YW'(1);
						state_q <= S_CNTRD;
					end
				end
				S_MGRD: state_q <= S_MGWR;
				S_MGWR: begin
					occ_vld_q[r_q] <= 1'b1;
					if (r_q == YW'(GRID_H - 1)) begin
						state_q <= S_CFIN;
					end else begin
						r_q     <= r_q + YW'(1);
						state_q <= S_MGRD;
					end
				end
				S_CFIN: begin
					obj_vld_q             <= '0;
					done_q                <= 1'b1;
					res_q.result_kind     <= KIND_CLOSE;
					res_q.hit_count       <= (32'(cnt_q) > 32'(HIT_MAX)) ? 10'(HIT_MAX) : 10'(cnt_q);
					res_q.accepted        <= (32'(cnt_q) >= 32'(minc_q));
					res_q.cell_class      <= CLS_EMPTY;
					state_q               <= S_IDLE;
				end
				S_QRD: begin
					qok_q   <= (q_ry >= 0) && (q_ry < GRID_H);
					qaddr_q <= YW'(q_ry);
					state_q <= S_QCAP;
				end
				S_QCAP: begin
					qrow_q[qk_q] <= (qok_q && occ_vld_q[qaddr_q]) ? occ_rdata : '0;
					if (qk_q == 2'd2) begin
						state_q <= S_QFIN;
					end else begin
						qk_q    <= qk_q + 2'd1;
						state_q <= S_QRD;
					end
				end
				S_QFIN: begin
					done_q           <= 1'b1;
					res_q.result_kind <= KIND_CLASS;
					res_q.hit_count  <= '0;
					res_q.accepted   <= 1'b0;
					res_q.cell_class <= q_cls;
					state_q          <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/raster_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raster_checker
// Watches the item, result and register channels of the triangle coverage
// grid rasterizer, keeps its own copy of the transform, vertex, object and
// occupancy state, predicts every close report and cell class, and compares
// each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module raster_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  tcgr_pkg::in_item_t  item,
	input  logic                done,
	input  tcgr_pkg::out_item_t result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  errors,
	output int                  pending,
	output int                  items_seen,
	output int                  results_seen,
	output int                  merges
);

	import tcgr_pkg::*;

	localparam int GW = GRID_W_DEF;
	localparam int GH = GRID_H_DEF;

	bit [31:0] coef[8];
	int        world_pos[6];
	bit        obj_map[GH][GW];
	bit        occ_map[GH][GW];
	longint    ctr_x;
	longint    ctr_y;
	longint    cell_w;
	int        min_hits;
	out_item_t expected_q[$];

	task automatic report(string what, out_item_t got, out_item_t want);
		$display("MISMATCH at %0t: %s (got %h, expected %h)", $time, what, got, want);
		errors++;
	endtask

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0) begin
			q--;
		end
		return q;
	endfunction

	function automatic int xform_row(int base, int x, int y, int z);
		logic signed [127:0] acc;
		longint p;
		acc = '0;
		p = longint'(signed'(coef[base])) * longint'(x);
		acc = acc + p;
		p = longint'(signed'(coef[base + 1])) * longint'(y);
		acc = acc + p;
		p = longint'(signed'(coef[base + 2])) * longint'(z);
		acc = acc + p;
		p = longint'(signed'(coef[base + 3])) * 256;
		acc = acc + p;
		acc = (acc + 128'sd32768) >>> 16;
		if (acc > 128'sd2147483647) begin
			return 32'h7fff_ffff;
		end
		if (acc < -128'sd2147483648) begin
			return 32'h8000_0000;
		end
		return int'(acc);
	endfunction

	function automatic int edge_sign(longint a, longint b, longint c, longint d);
		logic signed [129:0] ea, eb, ec, ed, w;
		ea = a;
		eb = b;
		ec = c;
		ed = d;
		w = ea * eb - ec * ed;
		if (w < 0) begin
			return -1;
		end
		return (w == 0) ? 0 : 1;
	endfunction

	task automatic rasterize();
		longint vx[3], vy[3];
		longint mnx, mxx, mny, mxy, gx0, gx1, gy0, gy1, px, py;
		int s1, s2, s3;
		for (int i = 0; i < 3; i++) begin
			vx[i] = world_pos[i];
			vy[i] = world_pos[3 + i];
		end
		mnx = vx[0];
		mxx = vx[0];
		mny = vy[0];
		mxy = vy[0];
		for (int i = 1; i < 3; i++) begin
			if (vx[i] < mnx) mnx = vx[i];
			if (vx[i] > mxx) mxx = vx[i];
			if (vy[i] < mny) mny = vy[i];
			if (vy[i] > mxy) mxy = vy[i];
		end
		gx0 = floor_div(mnx - ctr_x, cell_w) + GW / 2;
		gx1 = floor_div(mxx - ctr_x, cell_w) + GW / 2 + 1;
		gy0 = floor_div(mny - ctr_y, cell_w) + GH / 2;
		gy1 = floor_div(mxy - ctr_y, cell_w) + GH / 2 + 1;
		if (gx0 < 0) gx0 = 0;
		if (gy0 < 0) gy0 = 0;
		if (gx1 >= GW) gx1 = GW - 1;
		if (gy1 >= GH) gy1 = GH - 1;
		for (int i = 0; i < 3; i++) begin
			vx[i] = 2 * vx[i];
			vy[i] = 2 * vy[i];
		end
		for (longint gy = gy0; gy <= gy1; gy++) begin
			for (longint gx = gx0; gx <= gx1; gx++) begin
				px = 2 * ctr_x + 2 * (gx - GW / 2) * cell_w + cell_w;
				py = 2 * ctr_y + 2 * (gy - GH / 2) * cell_w + cell_w;
				s1 = edge_sign(px - vx[1], vy[0] - vy[1], vx[0] - vx[1], py - vy[1]);
				s2 = edge_sign(px - vx[2], vy[1] - vy[2], vx[1] - vx[2], py - vy[2]);
				s3 = edge_sign(px - vx[0], vy[2] - vy[0], vx[2] - vx[0], py - vy[0]);
				if (!((s1 < 0 || s2 < 0 || s3 < 0) && (s1 > 0 || s2 > 0 || s3 > 0))) begin
					obj_map[gy][gx] = 1'b1;
				end
			end
		end
	endtask

	function automatic bit occ_at(int x, int y);
		if (x < 0 || y < 0 || x >= GW || y >= GH) begin
			return 1'b0;
		end
		return occ_map[y][x];
	endfunction

	task automatic apply_item(in_item_t it);
		out_item_t r;
		int count;
		int x, y;
		bit vb, hb;
		r = '0;
		case (it.opcode)
			OP_COEF: begin
				coef[it.position_index] = it.coef_value;
			end
			OP_VERT: begin
				if (it.position_index <= 2) begin
					world_pos[it.position_index] = xform_row(0, it.vert_x, it.vert_y, it.vert_z);
					world_pos[3 + it.position_index] =
						xform_row(4, it.vert_x, it.vert_y, it.vert_z);
					if (it.position_index == 2) begin
						rasterize();
					end
				end
			end
			OP_CLOSE: begin
				count = 0;
				foreach (obj_map[j, i]) count += obj_map[j][i];
				r.result_kind = KIND_CLOSE;
				r.hit_count = 10'((count > HIT_MAX) ? HIT_MAX : count);
				r.accepted = (count >= min_hits);
				r.cell_class = CLS_EMPTY;
				if (r.accepted) begin
					merges++;
					foreach (obj_map[j, i]) occ_map[j][i] |= obj_map[j][i];
				end
				foreach (obj_map[j, i]) obj_map[j][i] = 1'b0;
				expected_q.push_back(r);
			end
			OP_QUERY: begin
				x = it.cell_x;
				y = it.cell_y;
				r.result_kind = KIND_CLASS;
				r.cell_class = CLS_EMPTY;
				if (occ_at(x, y)) begin
					vb = !occ_at(x, y - 1) || !occ_at(x, y + 1);
					hb = !occ_at(x - 1, y) || !occ_at(x + 1, y);
					if (!vb && !hb) r.cell_class = CLS_INTERIOR;
					else if (vb && hb) r.cell_class = CLS_CORNER;
					else if (vb) r.cell_class = CLS_HBORDER;
					else r.cell_class = CLS_VBORDER;
				end
				expected_q.push_back(r);
			end
			OP_CLROCC: begin
				foreach (occ_map[j, i]) occ_map[j][i] = 1'b0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			foreach (coef[i]) coef[i] = '0;
			foreach (world_pos[i]) world_pos[i] = 0;
			foreach (obj_map[j, i]) obj_map[j][i] = 1'b0;
			foreach (occ_map[j, i]) occ_map[j][i] = 1'b0;
			ctr_x = 0;
			ctr_y = 0;
			cell_w = CELL_SIZE_RST;
			min_hits = MIN_CELLS_RST;
			expected_q.delete();
			errors = 0;
			pending = 0;
			items_seen = 0;
			results_seen = 0;
			merges = 0;
		end else begin
			if (done) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report("result with nothing expected", result, '0);
				end else begin
					want = expected_q.pop_front();
					if (result.result_kind !== want.result_kind)
						report("result_kind", result, want);
					if (result.hit_count !== want.hit_count)
						report("hit_count", result, want);
					if (result.accepted !== want.accepted)
						report("accepted", result, want);
					if (result.cell_class !== want.cell_class)
						report("cell_class", result, want);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CENTER_X: ctr_x = longint'(signed'(cfg_data));
					CFG_CENTER_Y: ctr_y = longint'(signed'(cfg_data));
					CFG_CELL_SIZE: begin
						cell_w = cfg_data[30:0];
						if (cell_w == 0) cell_w = 1;
					end
					CFG_MIN_CELLS: min_hits = cfg_data[9:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				items_seen++;
				apply_item(item);
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the triangle coverage grid rasterizer with a short directed sequence
// and then with phases of random objects, queries and noise under several
// grid settings, pausing and bursting at random. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import tcgr_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int         ONE_Q16     = 65536;
	localparam int         PHASES      = 12;
	localparam int         PHASE_ITEMS = 160;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_item_t    item;
	logic        done;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	int          errors;
	int          pending;
	int          items_seen;
	int          results_seen;
	int          merges;

	longint cur_cx;
	longint cur_cy;
	longint cur_cs;
	int     burst_left;
	bit     no_gaps;
	bit     xform_dirty;
	int     sent;

	triangle_coverage_grid_raster_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	raster_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
		.pending(pending), .items_seen(items_seen), .results_seen(results_seen),
		.merges(merges)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#100_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return int'(v);
	endfunction

	// World point near the grid along one axis.
	function automatic int grid_point(longint ctr, int half);
		longint span;
		span = longint'(half + 2) * 1024;
		return clamp32(ctr + (longint'($urandom_range(0, 2 * span)) - span) * cur_cs / 1024);
	endfunction

	function automatic int near_point(int base, int cells);
		longint span;
		span = longint'(cells) * 1024;
		return clamp32(longint'(base) + (longint'($urandom_range(0, 2 * span)) - span) * cur_cs / 1024);
	endfunction

	function automatic in_item_t rand_item(logic [2:0] op, logic [2:0] idx);
		in_item_t it;
		it.opcode = op;
		it.position_index = idx;
		it.coef_value = $urandom;
		it.vert_x = $urandom;
		it.vert_y = $urandom;
		it.vert_z = $urandom;
		it.cell_x = 5'($urandom);
		it.cell_y = 4'($urandom);
		return it;
	endfunction

	task automatic send(in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				@(negedge clk) start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk) start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
		case (idx)
			CFG_CENTER_X: cur_cx = longint'(signed'(data));
			CFG_CENTER_Y: cur_cy = longint'(signed'(data));
			CFG_CELL_SIZE: cur_cs = (data[30:0] == 0) ? 1 : data[30:0];
			default: ;
		endcase
	endtask

	task automatic send_coef(logic [2:0] idx, int value);
		in_item_t it;
		it = rand_item(OP_COEF, idx);
		it.coef_value = value;
		send(it);
	endtask

	task automatic send_vertex(logic [2:0] idx, int x, int y, int z);
		in_item_t it;
		it = rand_item(OP_VERT, idx);
		it.vert_x = x;
		it.vert_y = y;
		it.vert_z = z;
		send(it);
	endtask

	task automatic send_query(int x, int y);
		in_item_t it;
		it = rand_item(OP_QUERY, 3'd0);
		it.cell_x = 5'(x);
		it.cell_y = 4'(y);
		send(it);
	endtask

	task automatic near_identity();
		bit exact;
		exact = ($urandom_range(0, 2) == 0);
		send_coef(3'd0, exact ? ONE_Q16 : ONE_Q16 + $urandom_range(0, 16384) - 8192);
		send_coef(3'd1, exact ? 0 : $urandom_range(0, 8192) - 4096);
		send_coef(3'd2, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) - 16 : 0);
		send_coef(3'd3, exact ? 0 : $urandom_range(0, 131072) - 65536);
		send_coef(3'd4, exact ? 0 : $urandom_range(0, 8192) - 4096);
		send_coef(3'd5, exact ? ONE_Q16 : ONE_Q16 + $urandom_range(0, 16384) - 8192);
		send_coef(3'd6, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) - 16 : 0);
		send_coef(3'd7, exact ? 0 : $urandom_range(0, 131072) - 65536);
		xform_dirty = 1'b0;
	endtask

	task automatic random_object();
		int tris, x0, y0, cells;
		if (xform_dirty || $urandom_range(0, 5) == 0) near_identity();
		tris = $urandom_range(1, 3);
		repeat (tris) begin
			cells = ($urandom_range(0, 4) == 0) ? 20 : 3;
			x0 = grid_point(cur_cx, GRID_W_DEF / 2);
			y0 = grid_point(cur_cy, GRID_H_DEF / 2);
			send_vertex(3'd0, x0, y0, $urandom_range(0, 4095) - 2048);
			send_vertex(3'd1, near_point(x0, cells), near_point(y0, cells),
				$urandom_range(0, 4095) - 2048);
			send_vertex(3'd2, near_point(x0, cells), near_point(y0, cells),
				$urandom_range(0, 4095) - 2048);
		end
		send(rand_item(OP_CLOSE, 3'($urandom)));
	endtask

	task automatic directed();
		int c;
		c = 12288;
		send_coef(3'd0, ONE_Q16);
		send_coef(3'd5, ONE_Q16);
		send_vertex(3'd0, -5 * c, -4 * c, 0);
		send_vertex(3'd1, 5 * c, -4 * c, 32'h7fff_ffff);
		send_vertex(3'd7, 0, 0, 0);
		send_vertex(3'd2, 0, 4 * c, 32'h8000_0000);
		for (logic [3:0] op = 4'(OP_SPARE_LO); op <= 4'(OP_SPARE_HI); op++) begin
			send(rand_item(op[2:0], 3'($urandom)));
		end
		send(rand_item(OP_CLOSE, 3'd0));
		send_query(16, 8);
		send_query(0, 0);
		send_query(31, 15);
		send_query(11, 4);
		// A triangle collapsed to one point on a cell centre still covers it.
		send_vertex(3'd0, c / 2, c / 2, 0);
		send_vertex(3'd1, c / 2, c / 2, 0);
		send_vertex(3'd2, c / 2, c / 2, 0);
		send(rand_item(OP_CLOSE, 3'd0));
		send_vertex(3'd0, 32'h7fff_0000, 32'h8000_0000, 0);
		send_vertex(3'd1, 32'h7fff_ffff, 32'h8000_0000, 0);
		send_vertex(3'd2, 32'h7fff_ffff, 32'h8001_0000, 0);
		send(rand_item(OP_CLOSE, 3'd0));
		send(rand_item(OP_CLROCC, 3'd0));
		send_query(16, 8);
		send_coef(3'd2, 32'h7fff_ffff);
		send_vertex(3'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_coef(3'd2, 0);
	endtask

	task automatic configure(int ph);
		case (ph)
			0: begin
				write_reg(CFG_CENTER_X, 0);
				write_reg(CFG_CENTER_Y, 0);
				write_reg(CFG_CELL_SIZE, CELL_SIZE_RST);
				write_reg(CFG_MIN_CELLS, MIN_CELLS_RST);
			end
			1: begin
				write_reg(CFG_CELL_SIZE, 1);
				write_reg(CFG_MIN_CELLS, 0);
			end
			2: begin
				write_reg(CFG_CENTER_X, 32'h8000_0000);
				write_reg(CFG_CENTER_Y, 32'h7fff_ffff);
				write_reg(CFG_CELL_SIZE, 32'hffff_ffff);
				write_reg(CFG_MIN_CELLS, 512);
			end
			3: begin
				write_reg(CFG_CENTER_X, 32'h7fff_ffff);
				write_reg(CFG_CENTER_Y, 32'h8000_0000);
				write_reg(CFG_CELL_SIZE, 32'h8000_0000);
				write_reg(CFG_MIN_CELLS, 1);
			end
			default: begin
				write_reg(CFG_CENTER_X, $urandom_range(0, 2097152) - 1048576);
				write_reg(CFG_CENTER_Y, $urandom_range(0, 2097152) - 1048576);
				write_reg(CFG_CELL_SIZE, {$urandom_range(0, 1) == 1,
					31'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
						: $urandom_range(64, 40000))});
				write_reg(CFG_MIN_CELLS, {22'($urandom), 10'($urandom_range(0, 12))});
			end
		endcase
	endtask

	task automatic run_phase(int count);
		int stop_at, pick;
		in_item_t it;
		stop_at = sent + count;
		no_gaps = ($urandom_range(0, 3) == 0);
		while (sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				random_object();
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 8)) send(rand_item(OP_QUERY, 3'($urandom)));
			end else if (pick < 84) begin
				send(rand_item(OP_CLROCC, 3'($urandom)));
			end else if (pick < 86) begin
				drain();
			end else begin
				it = rand_item(3'($urandom), 3'($urandom));
				if (it.opcode == OP_COEF) xform_dirty = 1'b1;
				send(it);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CENTER_X;
		cfg_data = '0;
		cur_cx = 0;
		cur_cy = 0;
		cur_cs = CELL_SIZE_RST;
		burst_left = 0;
		no_gaps = 1'b0;
		xform_dirty = 1'b0;
		sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		directed();
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			configure(ph);
			run_phase(PHASE_ITEMS);
		end
		drain();
		repeat (20) @(negedge clk);
		$display("Run covered %0d items and %0d results, %0d objects merged,", items_seen,
			results_seen, merges);
		$display("over %0d grid settings including extreme centres and cell sizes.", PHASES);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
